/* rtl/core/png_stored_deflate_encoder_assert.svh */
// Assertion macros used by the port checker of the PNG stored-deflate encoder.
`ifndef PNG_STORED_DEFLATE_ENCODER_ASSERT_SVH
`define PNG_STORED_DEFLATE_ENCODER_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PNGSE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pngse: check failed");

// Next-cycle implication, ignored while reset is asserted.
`define PNGSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pngse: check failed");

// Next-cycle implication that also holds across reset.
`define PNGSE_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pngse: reset check failed");

`endif

/* rtl/core/pngse_pkg.sv */
// Shared types, constants and functions of the PNG stored-deflate encoder.
package pngse_pkg;

  localparam int MAX_SIDE_DEF = 4096;
  localparam int FQ_DEPTH_DEF = 4;
  localparam int SIDE_W = 13;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

  localparam logic OP_START = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD = 17'd65521;
  localparam logic [15:0] BLOCK_MAX = 16'hFFFF;

  localparam logic [31:0] TAG_IHDR = 32'h49484452;
  localparam logic [31:0] TAG_IDAT = 32'h49444154;
  localparam logic [31:0] TAG_IEND = 32'h49454E44;
  localparam logic [7:0] ZLIB_CMF = 8'h78;
  localparam logic [7:0] ZLIB_FLG = 8'h01;
  localparam logic [7:0] IHDR_LEN = 8'd13;
  localparam logic [7:0] BIT_DEPTH = 8'd8;
  localparam logic [7:0] COLOR_RGBA = 8'd6;

  localparam logic [7:0] PNG_SIG [8] = '{8'd137, 8'd80, 8'd78, 8'd71,
                                         8'd13, 8'd10, 8'd26, 8'd10};

  typedef struct packed {
    logic       op;
    logic [7:0] pix;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       eof;
  } beat_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] k);
    return v[(3 - int'(k)) * 8 +: 8];
  endfunction

endpackage

/* rtl/core/pngse_front.sv */
// Input item queue that decouples the accepting side from the byte sequencer.
module pngse_front #(
  parameter int DEPTH = pngse_pkg::FQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pngse_pkg::item_t  item_in,
  output logic              full,
  output pngse_pkg::item_t  item_out,
  output logic              item_valid,
  input  logic              item_take
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  pngse_pkg::item_t mem_r [DEPTH];
  logic [PW-1:0] wr_r, rd_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full = (cnt_r == CW'(DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item_out = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop = item_take && item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/pngse_back.sv */
// Byte sequencer: file head, block headers, pixel data, checksums and trailer.
module pngse_back #(
  parameter int MAX_SIDE = pngse_pkg::MAX_SIDE_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [pngse_pkg::SIDE_W-1:0] cfg_w,
  input  logic [pngse_pkg::SIDE_W-1:0] cfg_h,
  input  pngse_pkg::item_t             item,
  input  logic                         item_valid,
  output logic                         item_take,
  input  logic                         space,
  output pngse_pkg::beat_t             beat,
  output logic                         beat_valid
);

  localparam int SW = pngse_pkg::SIDE_W;
  localparam int ROW_W = SW + 2;
  localparam int RAW_W = $clog2(MAX_SIDE * (4 * MAX_SIDE + 1) + 1);
  localparam int X_W = ((RAW_W > 16) ? RAW_W : 16) + 1;
  localparam int BLK_W = (RAW_W > 16) ? RAW_W - 15 : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_HEAD = 2'd1;
  localparam logic [1:0] ST_RAW = 2'd2;
  localparam logic [1:0] ST_TAIL = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic [5:0] idx_r, idx_nxt;
  logic [2:0] hk_r, hk_nxt;
  logic filt_r, filt_nxt;
  logic [7:0] pix_r, pix_nxt;
  logic active_r, active_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [15:0] alo_r, alo_nxt, ahi_r, ahi_nxt;
  logic [15:0] bleft_r, bleft_nxt;
  logic [RAW_W-1:0] rleft_r, rleft_nxt;
  logic [ROW_W-1:0] col_r, col_nxt;
  logic [SW-1:0] w_r, w_nxt, h_r, h_nxt;

  logic [RAW_W-1:0] raw_r;
  logic [BLK_W-1:0] blk_r;
  logic [31:0] idat_r;

  logic [SW+ROW_W-1:0] prod;
  logic [ROW_W-1:0] row_bytes;
  logic [X_W-1:0] xs, q0;
  logic [X_W:0] rem;
  logic [SW-1:0] w_cl, h_cl;
  logic [15:0] blen;
  logic [7:0] cur, bbyte;
  logic feed, restart;
  logic [31:0] crc_in;
  logic [16:0] lo1, hi1;
  logic [15:0] lo2, hi2;
  logic [1:0] k1;

  assign row_bytes = {w_r, 2'b00};
  assign prod = (SW + ROW_W)'(h_r) * (SW + ROW_W)'(row_bytes + 1'b1);
  assign xs = X_W'(raw_r) + X_W'(17'd65534);
  assign q0 = xs >> 16;
  assign rem = (X_W + 1)'(xs[15:0]) + (X_W + 1)'(q0);

  always_ff @(posedge clk) begin
    raw_r <= RAW_W'(prod);
    blk_r <= BLK_W'(q0 + X_W'(rem >= (X_W + 1)'(17'd65535)));
    idat_r <= 32'(raw_r) + (32'(blk_r) << 2) + 32'(blk_r) + 32'd6;
  end

  assign w_cl = (cfg_w == '0) ? SW'(1) :
                ((32'(cfg_w) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : cfg_w);
  assign h_cl = (cfg_h == '0) ? SW'(1) :
                ((32'(cfg_h) > 32'(MAX_SIDE)) ? SW'(MAX_SIDE) : cfg_h);
  assign blen = (32'(rleft_r) < 32'(pngse_pkg::BLOCK_MAX)) ? 16'(rleft_r)
                                                           : pngse_pkg::BLOCK_MAX;
  assign cur = filt_r ? 8'd0 : pix_r;
  assign k1 = 2'(idx_r - 6'd1);
  assign crc_in = restart ? pngse_pkg::CRC_INIT : crc_r;
  assign lo1 = {1'b0, alo_r} + 17'(cur);
  assign lo2 = (lo1 >= pngse_pkg::ADLER_MOD) ? 16'(lo1 - pngse_pkg::ADLER_MOD) : lo1[15:0];
  assign hi1 = {1'b0, ahi_r} + {1'b0, lo2};
  assign hi2 = (hi1 >= pngse_pkg::ADLER_MOD) ? 16'(hi1 - pngse_pkg::ADLER_MOD) : hi1[15:0];

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    hk_nxt = hk_r;
    filt_nxt = filt_r;
    pix_nxt = pix_r;
    active_nxt = active_r;
    alo_nxt = alo_r;
    ahi_nxt = ahi_r;
    bleft_nxt = bleft_r;
    rleft_nxt = rleft_r;
    col_nxt = col_r;
    w_nxt = w_r;
    h_nxt = h_r;
    item_take = 1'b0;
    beat_valid = 1'b0;
    bbyte = 8'd0;
    beat.last = 1'b0;
    beat.eof = 1'b0;
    feed = 1'b0;
    restart = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_take = 1'b1;
          if (item.op == pngse_pkg::OP_START) begin
            st_nxt = ST_HEAD;
            idx_nxt = '0;
            w_nxt = w_cl;
            h_nxt = h_cl;
          end else if (active_r) begin
            st_nxt = ST_RAW;
            hk_nxt = '0;
            pix_nxt = item.pix;
            if (col_r == '0) begin
              filt_nxt = 1'b1;
              col_nxt = row_bytes - 1'b1;
            end else begin
              filt_nxt = 1'b0;
              col_nxt = col_r - 1'b1;
            end
          end
        end
      end
      ST_HEAD: begin
        if (space) begin
          beat_valid = 1'b1;
          idx_nxt = idx_r + 1'b1;
          restart = (idx_r == 6'd12) || (idx_r == 6'd37);
          feed = ((idx_r >= 6'd12) && (idx_r <= 6'd28)) || (idx_r >= 6'd37);
          priority if (idx_r < 6'd8) bbyte = pngse_pkg::PNG_SIG[idx_r[2:0]];
          else if (idx_r < 6'd12) bbyte = pngse_pkg::be_byte(32'(pngse_pkg::IHDR_LEN), idx_r[1:0]);
          else if (idx_r < 6'd16) bbyte = pngse_pkg::be_byte(pngse_pkg::TAG_IHDR, idx_r[1:0]);
          else if (idx_r < 6'd20) bbyte = pngse_pkg::be_byte(32'(w_r), idx_r[1:0]);
          else if (idx_r < 6'd24) bbyte = pngse_pkg::be_byte(32'(h_r), idx_r[1:0]);
          else if (idx_r == 6'd24) bbyte = pngse_pkg::BIT_DEPTH;
          else if (idx_r == 6'd25) bbyte = pngse_pkg::COLOR_RGBA;
          else if (idx_r < 6'd29) bbyte = 8'd0;
          else if (idx_r < 6'd33) bbyte = pngse_pkg::be_byte(~crc_r, k1);
          else if (idx_r < 6'd37) bbyte = pngse_pkg::be_byte(idat_r, k1);
          else if (idx_r < 6'd41) bbyte = pngse_pkg::be_byte(pngse_pkg::TAG_IDAT, k1);
          else if (idx_r == 6'd41) bbyte = pngse_pkg::ZLIB_CMF;
          else bbyte = pngse_pkg::ZLIB_FLG;
          if (idx_r == 6'd42) begin
            beat.last = 1'b1;
            st_nxt = ST_IDLE;
            active_nxt = 1'b1;
            alo_nxt = 16'd1;
            ahi_nxt = 16'd0;
            bleft_nxt = '0;
            rleft_nxt = raw_r;
            col_nxt = '0;
          end
        end
      end
      ST_RAW: begin
        if (space) begin
          beat_valid = 1'b1;
          feed = 1'b1;
          if (bleft_r == '0) begin
            unique case (hk_r)
              3'd0: bbyte = {7'd0, (32'(rleft_r) <= 32'(pngse_pkg::BLOCK_MAX))};
              3'd1: bbyte = blen[7:0];
              3'd2: bbyte = blen[15:8];
              3'd3: bbyte = ~blen[7:0];
              3'd4: bbyte = ~blen[15:8];
              default: bbyte = 8'd0;
            endcase
            hk_nxt = hk_r + 1'b1;
            if (hk_r == 3'd4) begin
              hk_nxt = '0;
              bleft_nxt = blen;
            end
          end else begin
            bbyte = cur;
            alo_nxt = lo2;
            ahi_nxt = hi2;
            bleft_nxt = bleft_r - 1'b1;
            rleft_nxt = rleft_r - 1'b1;
            if (filt_r) begin
              filt_nxt = 1'b0;
            end else if (rleft_r == RAW_W'(1)) begin
              st_nxt = ST_TAIL;
              idx_nxt = '0;
            end else begin
              beat.last = 1'b1;
              st_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_TAIL: begin
        if (space) begin
          beat_valid = 1'b1;
          idx_nxt = idx_r + 1'b1;
          restart = (idx_r == 6'd12);
          feed = (idx_r < 6'd4) || ((idx_r >= 6'd12) && (idx_r < 6'd16));
          priority if (idx_r < 6'd4) bbyte = pngse_pkg::be_byte({ahi_r, alo_r}, idx_r[1:0]);
          else if (idx_r < 6'd8) bbyte = pngse_pkg::be_byte(~crc_r, idx_r[1:0]);
          else if (idx_r < 6'd12) bbyte = 8'd0;
          else if (idx_r < 6'd16) bbyte = pngse_pkg::be_byte(pngse_pkg::TAG_IEND, idx_r[1:0]);
          else bbyte = pngse_pkg::be_byte(~crc_r, idx_r[1:0]);
          if (idx_r == 6'd19) begin
            beat.last = 1'b1;
            beat.eof = 1'b1;
            st_nxt = ST_IDLE;
            active_nxt = 1'b0;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
    beat.data = bbyte;
    crc_nxt = feed ? pngse_pkg::crc_byte(crc_in, bbyte) : crc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      idx_r <= '0;
      hk_r <= '0;
      filt_r <= 1'b0;
      active_r <= 1'b0;
      crc_r <= pngse_pkg::CRC_INIT;
      alo_r <= 16'd1;
      ahi_r <= '0;
      bleft_r <= '0;
      rleft_r <= '0;
      col_r <= '0;
      w_r <= SW'(1);
      h_r <= SW'(1);
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
      hk_r <= hk_nxt;
      filt_r <= filt_nxt;
      active_r <= active_nxt;
      crc_r <= crc_nxt;
      alo_r <= alo_nxt;
      ahi_r <= ahi_nxt;
      bleft_r <= bleft_nxt;
      rleft_r <= rleft_nxt;
      col_r <= col_nxt;
      w_r <= w_nxt;
      h_r <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r <= pix_nxt;
  end

endmodule

/* rtl/core/pngse_outq.sv */
// Two-entry result queue between the byte sequencer and the output ports.
module pngse_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pngse_pkg::beat_t beat_in,
  output logic             space,
  output logic             empty,
  input  logic             pop,
  output pngse_pkg::beat_t beat_out
);

  pngse_pkg::beat_t mem_r [2];
  logic wr_r, rd_r;
  logic [1:0] cnt_r;
  logic do_pop;

  assign space = (cnt_r != 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign beat_out = mem_r[rd_r];
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= 1'b0;
      rd_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* rtl/core/png_stored_deflate_encoder.sv */
// Top level of the PNG stored-deflate encoder: config registers and the item path.
// Throughput: one output byte per cycle while the output queue has space; the sequencer
// fetches each item while idle and takes the next one only after the current one's last byte.
// An accepted item passes through the input queue and the sequencer into the output queue.
// Reset is synchronous and active low; it empties both queues and sets width and height to 1.
module png_stored_deflate_encoder #(
  parameter int MAX_SIDE = pngse_pkg::MAX_SIDE_DEF,
  parameter int FQ_DEPTH = pngse_pkg::FQ_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic                            in_op,
  input  logic [7:0]                      in_pixel_byte,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [7:0]                      out_out_byte,
  output logic                            out_last_of_run,
  output logic                            out_end_of_file,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pngse_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pngse_pkg::SIDE_W-1:0]    cfg_data
);

  logic [pngse_pkg::SIDE_W-1:0] width_r, height_r;
  pngse_pkg::item_t in_item, q_item;
  pngse_pkg::beat_t bk_beat, out_beat;
  logic q_valid, q_take, bk_valid, oq_space;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= pngse_pkg::SIDE_W'(1);
      height_r <= pngse_pkg::SIDE_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == pngse_pkg::REG_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == pngse_pkg::REG_HEIGHT) begin
        height_r <= cfg_data;
      end
    end
  end

  assign in_item.op = in_op;
  assign in_item.pix = in_pixel_byte;

  pngse_front #(.DEPTH(FQ_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .push(in_push), .item_in(in_item), .full(in_full),
    .item_out(q_item), .item_valid(q_valid), .item_take(q_take)
  );

  pngse_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk(clk), .rst_n(rst_n), .cfg_w(width_r), .cfg_h(height_r),
    .item(q_item), .item_valid(q_valid), .item_take(q_take),
    .space(oq_space), .beat(bk_beat), .beat_valid(bk_valid)
  );

  pngse_outq u_outq (
    .clk(clk), .rst_n(rst_n), .push(bk_valid), .beat_in(bk_beat), .space(oq_space),
    .empty(out_empty), .pop(out_pop), .beat_out(out_beat)
  );

  assign out_out_byte = out_beat.data;
  assign out_last_of_run = out_beat.last;
  assign out_end_of_file = out_beat.eof;

endmodule

/* rtl/core/pngse_port_checker.sv */
// Port-level checker for the PNG stored-deflate encoder and its bind.
`include "png_stored_deflate_encoder_assert.svh"

module pngse_port_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_full,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_out_byte,
  input logic       out_last_of_run,
  input logic       out_end_of_file
);

  `PNGSE_ASSERT_NOW(a_eof_is_last, !out_empty && out_end_of_file, out_last_of_run)
  `PNGSE_ASSERT_NEXT(a_beat_held, !out_empty && !out_pop, !out_empty && $stable(out_out_byte))
  `PNGSE_ASSERT_RST(a_rst_out_empty, !rst_n, out_empty)
  `PNGSE_ASSERT_RST(a_rst_in_open, !rst_n, !in_full)

endmodule

bind png_stored_deflate_encoder pngse_port_checker u_port_checker (.*);

/* verif/tb_png_stored_deflate_encoder.sv */
// Self-checking testbench of the PNG stored-deflate encoder, with its own byte stream predictor.
`timescale 1ns / 100ps

module tb_png_stored_deflate_encoder;
  import pngse_pkg::*;

  localparam int LIMIT = 4000000;
  localparam int DRAIN = 20;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic                 in_op;
  logic [7:0]           in_pixel_byte;
  logic                 out_empty;
  logic                 out_pop;
  logic [7:0]           out_out_byte;
  logic                 out_last_of_run;
  logic                 out_end_of_file;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SIDE_W-1:0]    cfg_data;

  png_stored_deflate_encoder u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op), .in_pixel_byte(in_pixel_byte),
    .out_empty(out_empty), .out_pop(out_pop), .out_out_byte(out_out_byte),
    .out_last_of_run(out_last_of_run), .out_end_of_file(out_end_of_file),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  beat_t       file_bytes_q[$];
  int          mismatches = 0;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_req = 0;
  int          hold_left = 0;

  logic [12:0] side_w_reg;
  logic [12:0] side_h_reg;
  logic [31:0] crc_acc;
  logic [16:0] adler_lo;
  logic [16:0] adler_hi;
  logic [31:0] block_left;
  logic [31:0] raw_left;
  logic [31:0] col_left;
  logic [31:0] rows_left;
  logic [31:0] row_len;
  logic        in_image;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL png_stored_deflate_encoder");
      $finish;
    end
  end

  function automatic logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    return r;
  endfunction

  function automatic logic [31:0] side_clamp(logic [12:0] v);
    if (v == 0) return 1;
    if (v > MAX_SIDE_DEF) return MAX_SIDE_DEF;
    return 32'(v);
  endfunction

  task automatic put_byte(logic [7:0] b, bit with_crc);
    beat_t e;
    if (with_crc) crc_acc = crc_next(crc_acc, b);
    e.data = b;
    e.last = 1'b0;
    e.eof = 1'b0;
    file_bytes_q = {file_bytes_q, e};
  endtask

  task automatic put_word(logic [31:0] v, bit with_crc);
    for (int s = 3; s >= 0; s--) put_byte(v[s*8 +: 8], with_crc);
  endtask

  task automatic put_payload(logic [7:0] b);
    logic [31:0] len;
    logic [15:0] nlen;
    if (block_left == 0) begin
      len = (raw_left < 65535) ? raw_left : 65535;
      nlen = ~len[15:0];
      put_byte((raw_left <= 65535) ? 8'd1 : 8'd0, 1'b1);
      put_byte(len[7:0], 1'b1);
      put_byte(len[15:8], 1'b1);
      put_byte(nlen[7:0], 1'b1);
      put_byte(nlen[15:8], 1'b1);
      block_left = len;
    end
    put_byte(b, 1'b1);
    adler_lo = adler_lo + b;
    if (adler_lo >= ADLER_MOD) adler_lo = adler_lo - ADLER_MOD;
    adler_hi = adler_hi + adler_lo;
    if (adler_hi >= ADLER_MOD) adler_hi = adler_hi - ADLER_MOD;
    if (block_left != 0) block_left--;
    if (raw_left != 0) raw_left--;
  endtask

  task automatic predict_file_bytes(logic op, logic [7:0] pix);
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] raw;
    logic [31:0] nblk;
    int          first;
    first = file_bytes_q.size();
    if (op == OP_START) begin
      w = side_clamp(side_w_reg);
      h = side_clamp(side_h_reg);
      raw = h * (1 + 4 * w);
      nblk = (raw + 65534) / 65535;
      for (int i = 0; i < 8; i++) put_byte(PNG_SIG[i], 1'b0);
      put_word(32'd13, 1'b0);
      crc_acc = CRC_INIT;
      put_word(TAG_IHDR, 1'b1);
      put_word(w, 1'b1);
      put_word(h, 1'b1);
      put_byte(BIT_DEPTH, 1'b1);
      put_byte(COLOR_RGBA, 1'b1);
      put_byte(8'd0, 1'b1);
      put_byte(8'd0, 1'b1);
      put_byte(8'd0, 1'b1);
      put_word(~crc_acc, 1'b0);
      put_word(32'd2 + raw + 32'd5 * nblk + 32'd4, 1'b0);
      crc_acc = CRC_INIT;
      put_word(TAG_IDAT, 1'b1);
      put_byte(ZLIB_CMF, 1'b1);
      put_byte(ZLIB_FLG, 1'b1);
      adler_lo = 17'd1;
      adler_hi = 17'd0;
      block_left = 0;
      raw_left = raw;
      col_left = 0;
      rows_left = h;
      row_len = 4 * w;
      in_image = 1'b1;
    end else begin
      if (!in_image) return;
      if (col_left == 0) begin
        put_payload(8'd0);
        col_left = row_len;
        if (rows_left != 0) rows_left--;
      end
      put_payload(pix);
      if (col_left != 0) col_left--;
      if (raw_left == 0) begin
        put_word({adler_hi[15:0], adler_lo[15:0]}, 1'b1);
        put_word(~crc_acc, 1'b0);
        put_word(32'd0, 1'b0);
        crc_acc = CRC_INIT;
        put_word(TAG_IEND, 1'b1);
        put_word(~crc_acc, 1'b0);
        file_bytes_q[$].eof = 1'b1;
        in_image = 1'b0;
      end
    end
    if (file_bytes_q.size() > first) file_bytes_q[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    beat_t e;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (file_bytes_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: byte %h", out_out_byte);
        end else begin
          e = file_bytes_q.pop_front();
          if (e.data !== out_out_byte || e.last !== out_last_of_run ||
              e.eof !== out_end_of_file) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h/%b/%b, got %h/%b/%b", e.data, e.last, e.eof,
                       out_out_byte, out_last_of_run, out_end_of_file);
          end
        end
      end
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_pop <= 1'b0;
        hold_left--;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  task automatic send_item(logic op, logic [7:0] pix);
    if ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_op <= op;
    in_pixel_byte <= pix;
    @(posedge clk);
    while (in_full) @(posedge clk);
    predict_file_bytes(op, pix);
  endtask

  task automatic stop_sending();
    in_push <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_WIDTH) side_w_reg = val;
    else if (idx == REG_HEIGHT) side_h_reg = val;
  endtask

  task automatic wait_drained();
    while (file_bytes_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_image(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h, int npix);
    stop_sending();
    wait_drained();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    send_item(OP_START, 8'($urandom_range(255)));
    for (int i = 0; i < npix; i++) send_item(OP_PIXEL, 8'($urandom_range(255)));
  endtask

  task automatic test_reset_values();
    send_item(OP_PIXEL, 8'hA5);
    send_item(OP_START, 8'h00);
    send_item(OP_PIXEL, 8'h00);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h5A);
    send_item(OP_PIXEL, 8'hFF);
    send_item(OP_PIXEL, 8'h33);
  endtask

  task automatic test_size_clamp();
    send_image(13'd0, 13'd0, 4);
    send_image(13'd8191, 13'd5000, 6);
    send_item(OP_START, 8'hFF);
    send_item(OP_PIXEL, 8'h80);
  endtask

  task automatic test_spare_index();
    send_image(13'd1, 13'd2, 0);
    stop_sending();
    wait_drained();
    write_reg(REG_SPARE_A, 13'h1555);
    write_reg(REG_SPARE_B, 13'h0AAA);
    write_reg(REG_WIDTH, 13'd2);
    for (int i = 0; i < 8; i++) send_item(OP_PIXEL, 8'($urandom_range(255)));
    send_item(OP_START, 8'h01);
    for (int i = 0; i < 8; i++) send_item(OP_PIXEL, 8'($urandom_range(255)));
  endtask

  task automatic test_random(int snd, int rcv, int nitems);
    int sent;
    int w;
    int h;
    int npix;
    send_idle = snd;
    recv_idle = rcv;
    sent = 0;
    while (sent < nitems) begin
      w = $urandom_range(3, 1);
      h = $urandom_range(3, 1);
      npix = 4 * w * h;
      if ($urandom_range(9) == 0) npix = $urandom_range(npix - 1);
      send_image(SIDE_W'(w), SIDE_W'(h), npix);
      if ($urandom_range(4) == 0) send_item(OP_PIXEL, 8'($urandom_range(255)));
      sent += npix + 1;
    end
  endtask

  task automatic test_backpressure();
    send_image(13'd4, 13'd4, 0);
    hold_req = 400;
    for (int i = 0; i < 32; i++) send_item(OP_PIXEL, 8'($urandom_range(255)));
    stop_sending();
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_op = 1'b0;
    in_pixel_byte = 8'd0;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    side_w_reg = 13'd1;
    side_h_reg = 13'd1;
    crc_acc = CRC_INIT;
    adler_lo = 17'd1;
    adler_hi = 17'd0;
    block_left = 0;
    raw_left = 0;
    col_left = 0;
    rows_left = 0;
    row_len = 0;
    in_image = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_size_clamp();
    test_spare_index();
    test_random(7, 65, 16);
    test_backpressure();
    test_random(65, 7, 12);
    test_random(0, 0, 12);
    stop_sending();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS png_stored_deflate_encoder");
    end else begin
      $display("FAIL png_stored_deflate_encoder");
    end
    $finish;
  end

endmodule
